/* rtl/smc_pkg.sv */
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants for the segment mean colour block: default sizes,
// item op codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

  localparam int SMC_MAX_LABELS = 1024;
  localparam int SMC_COUNT_BITS = 22;

  localparam int LABEL_W     = 10;
  localparam int CHAN_W      = 8;
  localparam int TOTAL_W     = 22;
  localparam int LCOUNT_W    = 11;
  localparam int QUOT_BITS   = 8;
  localparam int STEP_W      = $clog2(QUOT_BITS);

  localparam logic [LCOUNT_W-1:0] LABEL_COUNT_RESET = 11'd1024;

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE,
    ST_RESULT
  } smc_state_t;

  typedef struct packed {
    logic capture;
    logic acc_write;
    logic div_load;
    logic div_step;
    logic clear_write;
    logic out_load;
  } smc_cmd_t;

  typedef struct packed {
    logic item_op;
    logic item_ok;
    logic clear_last;
    logic div_last;
    logic out_busy;
  } smc_status_t;

endpackage

`default_nettype wire

/* rtl/smc_ctrl.sv */
// ----------------------------------------------------------------------------
// smc_ctrl
// Controller: sequences the clearing pass, the entry lookup, the accumulate
// write-back, the iterative mean division and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_ctrl
  import smc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  smc_status_t status,
  output smc_cmd_t    cmd
);

  smc_state_t state;
  smc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!status.item_ok) begin
          state_next = (status.item_op == OP_READ) ? ST_RESULT : ST_IDLE;
        end else if (status.item_op == OP_ACCUMULATE) begin
          cmd.acc_write = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.div_load = 1'b1;
          state_next   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/smc_datapath.sv */
// ----------------------------------------------------------------------------
// smc_datapath
// Datapath: per-label store of count, channel sums and overflow mark, the
// request register, a radix-2 divider with one lane per mean on a shared divisor,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_datapath
  import smc_pkg::*;
#(
  parameter int MAX_LABELS = SMC_MAX_LABELS,
  parameter int COUNT_BITS = SMC_COUNT_BITS
)
(
  input  logic                clk,
  input  logic                rst,
  input  smc_cmd_t            cmd,
  output smc_status_t         status,
  input  logic                cfg_wr_en,
  input  logic [LCOUNT_W-1:0] cfg_wr_data,
  input  logic                op,
  input  logic [LABEL_W-1:0]  label,
  input  logic [CHAN_W-1:0]   chan0,
  input  logic [CHAN_W-1:0]   chan1,
  input  logic [CHAN_W-1:0]   chan2,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LABEL_W-1:0]  label_out,
  output logic [CHAN_W-1:0]   mean0,
  output logic [CHAN_W-1:0]   mean1,
  output logic [CHAN_W-1:0]   mean2,
  output logic [TOTAL_W-1:0]  pixel_total,
  output logic                empty_res,
  output logic                bad_label,
  output logic                saturated
);

  localparam int ADDR_W  = $clog2(MAX_LABELS);
  localparam int SUM_W   = COUNT_BITS + CHAN_W;
  localparam int CNT_LO  = 0;
  localparam int S0_LO   = COUNT_BITS;
  localparam int S1_LO   = COUNT_BITS + SUM_W;
  localparam int S2_LO   = COUNT_BITS + 2 * SUM_W;
  localparam int MARK_B  = COUNT_BITS + 3 * SUM_W;
  localparam int ENTRY_W = MARK_B + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(MAX_LABELS - 1);

  logic [ENTRY_W-1:0] mem [MAX_LABELS];
  logic [ENTRY_W-1:0] rd_data;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [ENTRY_W-1:0]  acc_entry;

  logic [LCOUNT_W-1:0] label_count;
  logic [ADDR_W-1:0]   clr_addr;

  logic [31:0]         label_w;
  logic [ADDR_W-1:0]   in_addr;
  logic                in_ok;

  logic                item_op;
  logic                item_ok;
  logic [LABEL_W-1:0]  item_label;
  logic [ADDR_W-1:0]   item_addr;
  logic [CHAN_W-1:0]   item_chan [3];

  logic [COUNT_BITS-1:0] cur_cnt;
  logic [SUM_W-1:0]      cur_sum [3];
  logic                  cur_mark;
  logic [SUM_W-1:0]      new_sum [3];

  logic [COUNT_BITS-1:0] div_cnt;
  logic [SUM_W-1:0]      rem [3];
  logic [QUOT_BITS-1:0]  quot [3];
  logic [STEP_W-1:0]     div_step_r;
  logic [SUM_W-1:0]      dvs_shift;
  logic                  fits [3];
  logic                  empty_r;
  logic                  mark_r;
  logic [31:0]           cnt_w;

  // request decode
  always_comb begin
    label_w = 32'(label);
    in_addr = label_w[ADDR_W-1:0];
    in_ok   = ({1'b0, label} < label_count) && (label_w < 32'(MAX_LABELS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      label_count <= LABEL_COUNT_RESET;
    end else if (cfg_wr_en) begin
      label_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op      <= op;
      item_ok      <= in_ok;
      item_label   <= label;
      item_addr    <= in_addr;
      item_chan[0] <= chan0;
      item_chan[1] <= chan1;
      item_chan[2] <= chan2;
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_write) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // entry update
  always_comb begin
    cur_cnt    = rd_data[CNT_LO +: COUNT_BITS];
    cur_sum[0] = rd_data[S0_LO +: SUM_W];
    cur_sum[1] = rd_data[S1_LO +: SUM_W];
    cur_sum[2] = rd_data[S2_LO +: SUM_W];
    cur_mark   = rd_data[MARK_B];
    for (int i = 0; i < 3; i++) begin
      new_sum[i] = cur_sum[i] + SUM_W'(item_chan[i]);
    end
    if (cur_cnt == COUNT_MAX) begin
      acc_entry = {1'b1, cur_sum[2], cur_sum[1], cur_sum[0], cur_cnt};
    end else begin
      acc_entry = {cur_mark, new_sum[2], new_sum[1], new_sum[0],
                   cur_cnt + COUNT_BITS'(1)};
    end
  end

  always_comb begin
    wr_en   = cmd.clear_write | cmd.acc_write | cmd.div_load;
    wr_addr = cmd.clear_write ? clr_addr : item_addr;
    wr_data = cmd.acc_write ? acc_entry : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= mem[in_addr];
    end
  end

  // mean division, one quotient bit per cycle for all three channels
  always_comb begin
    dvs_shift = SUM_W'(div_cnt) << div_step_r;
    for (int i = 0; i < 3; i++) begin
      fits[i] = (rem[i] >= dvs_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_cnt    <= cur_cnt;
      div_step_r <= STEP_W'(QUOT_BITS - 1);
      empty_r    <= (cur_cnt == '0);
      mark_r     <= cur_mark;
      for (int i = 0; i < 3; i++) begin
        rem[i]  <= cur_sum[i];
        quot[i] <= '0;
      end
    end else if (cmd.div_step) begin
      div_step_r <= div_step_r - STEP_W'(1);
      for (int i = 0; i < 3; i++) begin
        if (fits[i]) begin
          rem[i] <= rem[i] - dvs_shift;
        end
        quot[i] <= {quot[i][QUOT_BITS-2:0], fits[i]};
      end
    end
  end

  // result register
  assign cnt_w = 32'(div_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      label_out <= item_label;
      bad_label <= !item_ok;
      if (!item_ok) begin
        mean0       <= '0;
        mean1       <= '0;
        mean2       <= '0;
        pixel_total <= '0;
        empty_res   <= 1'b0;
        saturated   <= 1'b0;
      end else begin
        mean0       <= empty_r ? '0 : quot[0];
        mean1       <= empty_r ? '0 : quot[1];
        mean2       <= empty_r ? '0 : quot[2];
        pixel_total <= cnt_w[TOTAL_W-1:0];
        empty_res   <= empty_r;
        saturated   <= mark_r;
      end
    end
  end

  always_comb begin
    status.item_op    = item_op;
    status.item_ok    = item_ok;
    status.clear_last = (clr_addr == LAST_ADDR);
    status.div_last   = (div_step_r == '0);
    status.out_busy   = out_valid & out_stall;
  end

endmodule

`default_nettype wire

/* rtl/segment_mean_colour.sv */
// ----------------------------------------------------------------------------
// segment_mean_colour
// Per-label mean colour pooling. Input requests either accumulate a pixel
// (op = accumulate) into its label's count and channel sums, or read a label
// (op = read) and return its truncated channel means and pixel count, after
// which the label's entry is cleared for the next frame.
// Both channels use valid/stall; a request moves when valid is high and stall
// is low. label_count is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, which the block does not enforce. An accumulate
// does a store read, then the write-back. A read does a store read, the
// divider load, the divider steps (one quotient bit per cycle for the three
// channels in parallel) and the result load; a bad label read skips the
// divider and a bad label accumulate is dropped. Reset: label_count returns
// to 1024 and a clearing pass writes every store entry, with in_stall high
// throughout. The result sits in an output register; a new request is taken
// while it waits, but the next read result stays held until out_stall drops.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_mean_colour
  import smc_pkg::*;
#(
  parameter int MAX_LABELS = SMC_MAX_LABELS,
  parameter int COUNT_BITS = SMC_COUNT_BITS
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [LCOUNT_W-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [LABEL_W-1:0]  label,
  input  logic [CHAN_W-1:0]   chan0,
  input  logic [CHAN_W-1:0]   chan1,
  input  logic [CHAN_W-1:0]   chan2,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LABEL_W-1:0]  label_out,
  output logic [CHAN_W-1:0]   mean0,
  output logic [CHAN_W-1:0]   mean1,
  output logic [CHAN_W-1:0]   mean2,
  output logic [TOTAL_W-1:0]  pixel_total,
  output logic                empty_res,
  output logic                bad_label,
  output logic                saturated
);

  smc_cmd_t    cmd;
  smc_status_t status;

  smc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  smc_datapath #(
    .MAX_LABELS (MAX_LABELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op          (op),
    .label       (label),
    .chan0       (chan0),
    .chan1       (chan1),
    .chan2       (chan2),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .label_out   (label_out),
    .mean0       (mean0),
    .mean1       (mean1),
    .mean2       (mean2),
    .pixel_total (pixel_total),
    .empty_res   (empty_res),
    .bad_label   (bad_label),
    .saturated   (saturated)
  );

endmodule

`default_nettype wire

/* rtl/smc_checker.sv */
// ----------------------------------------------------------------------------
// smc_checker
// Port-level checks for segment_mean_colour: result flag consistency, one
// request in flight at a time and a held result under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_checker
  import smc_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [LABEL_W-1:0]  label_out,
  input wire logic [CHAN_W-1:0]   mean0,
  input wire logic [CHAN_W-1:0]   mean1,
  input wire logic [CHAN_W-1:0]   mean2,
  input wire logic [TOTAL_W-1:0]  pixel_total,
  input wire logic                empty_res,
  input wire logic                bad_label,
  input wire logic                saturated
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(label_out) && $stable(mean0)
      && $stable(pixel_total) && $stable(bad_label))
    else $error("result changed while stalled");

  // bad label result carries nothing else
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_label |-> mean0 == '0 && mean1 == '0 && mean2 == '0
      && pixel_total == '0 && !empty_res && !saturated)
    else $error("bad label result not cleared");

  // empty label gives zero means and count
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> mean0 == '0 && mean1 == '0 && mean2 == '0
      && pixel_total == '0)
    else $error("empty label result not zero");

  // one request in flight
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous still in work");

endmodule

bind segment_mean_colour smc_checker u_smc_checker (.*);

`default_nettype wire
